FILE: rtl/wrc_pkg.sv
package wrc_pkg;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_MODIFY = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_LOOKUP = 2'd3
	} action_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// one filter rule, also used as the lookup key (allow unused there)
	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        allow;
	} rule_t;

	// first-match result travelling down the row of cells
	typedef struct packed {
		logic       tok;
		logic       found;
		logic       allow;
		logic [6:0] slot;
	} chain_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic wr;
		logic shift;
	} cell_cmd_t;

	typedef struct packed {
		logic       hit;
		logic       verdict;
		logic [6:0] matched_slot;
		logic [1:0] status;
		logic [6:0] count_now;
	} result_t;

endpackage

FILE: rtl/wrc_cell.sv
module wrc_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wrc_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]     wr_idx,
	input  logic [CW-1:0]     shift_from,
	input  logic [CW-1:0]     count,
	input  wrc_pkg::rule_t    wr_rule,
	input  wrc_pkg::rule_t    nb_rule,
	input  wrc_pkg::rule_t    key,
	input  logic              port_check,
	input  wrc_pkg::chain_t   chain_in,
	output wrc_pkg::chain_t   chain_out,
	output wrc_pkg::rule_t    rule_out
);
	import wrc_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic [6:0] MY_SLOT = 7'(IDX + 1);

	rule_t  rule_q;
	chain_t chain_q;
	logic   active;
	logic   addr_ok;
	logic   port_ok;
	logic   match;

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_idx == MY_IDX) begin
			rule_q <= wr_rule;
		end else if (cmd.shift && shift_from <= MY_IDX) begin
			rule_q <= nb_rule;
		end
	end

	assign active  = MY_IDX < count;
	assign addr_ok = (rule_q.proto == key.proto || rule_q.proto == '0)
		&& (rule_q.src_ip == key.src_ip || rule_q.src_ip == '0)
		&& (rule_q.dst_ip == key.dst_ip || rule_q.dst_ip == '0);
	assign port_ok = (rule_q.sport == key.sport || rule_q.sport == '0)
		&& (rule_q.dport == key.dport || rule_q.dport == '0);
	assign match   = active && addr_ok && (!port_check || port_ok);

	// an earlier match wins, otherwise a match in this cell claims the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else begin
			chain_q.tok <= chain_in.tok;
			if (chain_in.found || !match) begin
				chain_q.found <= chain_in.found;
				chain_q.allow <= chain_in.allow;
				chain_q.slot  <= chain_in.slot;
			end else begin
				chain_q.found <= 1'b1;
				chain_q.allow <= rule_q.allow;
				chain_q.slot  <= MY_SLOT;
			end
		end
	end

	assign chain_out = chain_q;
	assign rule_out  = rule_q;

endmodule

FILE: rtl/wildcard_rule_classifier_unit.sv
// First-match five-tuple classifier built as a row of MAX_RULES cells, one rule per cell.
// Add, modify and delete updates are broadcast to all cells, and a delete shifts every
// later rule down one cell at once. A lookup holds the tuple on a shared bus while a match
// token walks the row one cell per cycle; the response is formed when the token leaves the
// last cell. One request is in flight at a time; a finished response may wait in the
// output register while the next request is accepted, but one that finds the output
// register still full waits in a one-entry pending register, stalling new requests.
module wildcard_rule_classifier_unit #(
	parameter int MAX_RULES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  action,
	input  logic [6:0]  slot,
	input  logic [7:0]  protocol,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] sport,
	input  logic [15:0] dport,
	input  logic        permit,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic        verdict,
	output logic [6:0]  matched_slot,
	output logic [1:0]  status,
	output logic [6:0]  count_now
);
	import wrc_pkg::*;

	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_RULES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PEND
	} state_t;

	state_t        state_q, state_d;
	logic          rsp_valid_q;
	logic          tok_q;
	logic [CW-1:0] count_q;
	rule_t         key_q;
	result_t       pend_q;
	result_t       rsp_q;
	result_t       res_d;
	logic          load_rsp;
	logic          load_pend;

	logic          accept;
	logic          is_lookup;
	logic          out_free;
	logic [XW-1:0] slot_x;
	logic [XW-1:0] count_x;
	logic          slot_ok;
	logic          full;
	logic [CW-1:0] slot_m1;
	logic [CW-1:0] count_d;
	logic [1:0]    upd_status;

	cell_cmd_t     cmd;
	logic [CW-1:0] wr_idx;
	rule_t         wr_rule;
	logic          port_check;

	chain_t        chain [MAX_RULES+1];
	rule_t         rules [MAX_RULES];

	assign accept    = req_valid && !req_stall;
	assign is_lookup = action == ACT_LOOKUP;
	assign req_stall = state_q != S_IDLE;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign slot_x  = XW'(slot);
	assign count_x = XW'(count_q);
	assign slot_ok = slot_x != '0 && slot_x <= count_x && slot_x <= MAX_X;
	assign full    = count_x >= MAX_X;
	assign slot_m1 = CW'(slot_x - XW'(1));

	assign wr_rule = '{proto: protocol, src_ip: src_ip, dst_ip: dst_ip,
		sport: sport, dport: dport, allow: permit};

	// table updates and the rule count after this request
	always_comb begin
		cmd        = '0;
		wr_idx     = count_q;
		count_d    = count_q;
		upd_status = ST_OK;
		if (accept) begin
			case (action)
				ACT_ADD: begin
					if (full) begin
						upd_status = ST_FULL;
					end else begin
						cmd.wr  = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				ACT_MODIFY: begin
					wr_idx = slot_m1;
					if (slot_ok) begin
						cmd.wr = 1'b1;
					end else begin
						upd_status = ST_RANGE;
					end
				end
				ACT_DELETE: begin
					if (slot_ok) begin
						cmd.shift = 1'b1;
						count_d   = count_q - CW'(1);
					end else begin
						upd_status = ST_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign port_check = key_q.proto == PROTO_TCP || key_q.proto == PROTO_UDP;
	assign chain[0]   = '{tok: tok_q, found: 1'b0, allow: 1'b0, slot: 7'd0};

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		rule_t nb;
		if (i + 1 < MAX_RULES) begin : g_mid
			assign nb = rules[i+1];
		end else begin : g_end
			assign nb = rules[i];
		end
		wrc_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.wr_idx     (wr_idx),
			.shift_from (slot_m1),
			.count      (count_q),
			.wr_rule    (wr_rule),
			.nb_rule    (nb),
			.key        (key_q),
			.port_check (port_check),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.rule_out   (rules[i])
		);
	end

	always_comb begin
		state_d   = state_q;
		load_rsp  = 1'b0;
		load_pend = 1'b0;
		res_d     = pend_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_lookup) begin
						state_d = S_SCAN;
					end else begin
						res_d = '{hit: 1'b0, verdict: 1'b0, matched_slot: 7'd0,
							status: upd_status, count_now: 7'(count_d)};
						if (out_free) begin
							load_rsp = 1'b1;
						end else begin
							load_pend = 1'b1;
							state_d   = S_PEND;
						end
					end
				end
			end
			S_SCAN: begin
				if (chain[MAX_RULES].tok) begin
					res_d = '{hit: chain[MAX_RULES].found,
						verdict: chain[MAX_RULES].found && chain[MAX_RULES].allow,
						matched_slot: chain[MAX_RULES].found ? chain[MAX_RULES].slot : 7'd0,
						status: ST_OK, count_now: 7'(count_q)};
					if (out_free) begin
						load_rsp = 1'b1;
						state_d  = S_IDLE;
					end else begin
						load_pend = 1'b1;
						state_d   = S_PEND;
					end
				end
			end
			S_PEND: begin
				if (out_free) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			tok_q       <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			tok_q   <= accept && is_lookup;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= wr_rule;
		end
		if (load_pend) begin
			pend_q <= res_d;
		end
		if (load_rsp) begin
			rsp_q <= res_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = rsp_q.hit;
	assign verdict      = rsp_q.verdict;
	assign matched_slot = rsp_q.matched_slot;
	assign status       = rsp_q.status;
	assign count_now    = rsp_q.count_now;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_x <= MAX_X)
		else $error("rule count above table size");

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_RULES].tok |-> state_q == S_SCAN)
		else $error("match token left the row outside a lookup");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("rule count changed without a request");

	a_hit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.hit) |-> (rsp_q.matched_slot != 7'd0 && rsp_q.status == ST_OK))
		else $error("hit response without a slot");

endmodule
